// ===== hw/rtl/rwrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rwrs_pkg
// Shared widths, operation codes and status codes of the rank-weighted
// roulette selector.
// ----------------------------------------------------------------------------
package rwrs_pkg;

  // Default sizing of the selector.
  localparam int DEF_MAX_POOL  = 256;
  localparam int DEF_RAND_BITS = 16;

  // Fixed port widths.
  localparam int POOL_W   = 9;
  localparam int OPCODE_W = 1;
  localparam int RAND_W   = 16;
  localparam int RANK_W   = 8;
  localparam int STATUS_W = 2;

  // Operation codes of an input item.
  localparam logic [OPCODE_W-1:0] OP_BEGIN = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REPEAT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

endpackage

// ===== hw/rtl/rank_weighted_roulette_select.sv =====
// ----------------------------------------------------------------------------
// rank_weighted_roulette_select
// Linear rank roulette-wheel selection over a cumulative weight table that
// is held in a synchronous memory and scanned one entry per cycle.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, in_opcode, in_rand_fraction | in
//  result  | out_valid, out_ready, out_picked_rank, out_status | out
//  config  | cfg_wr_en, cfg_wr_data (pool_size)           | in
//
//  Begin: the table is rebuilt when the saturated size changed to a nonzero one.
//  Draw: a multiply state, then a scan over the entries; the result is
//  registered when the scan ends, or in the multiply state for an empty pool.
//  Reset is synchronous, active low; the table memory needs no clearing pass.
//  While a result waits, a new item is still accepted, but a draw that ends
//  before the result is taken holds in place and blocks the input.
//
module rank_weighted_roulette_select #(
  parameter int MAX_POOL  = rwrs_pkg::DEF_MAX_POOL,
  parameter int RAND_BITS = rwrs_pkg::DEF_RAND_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rwrs_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [rwrs_pkg::RAND_W-1:0]   in_rand_fraction,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rwrs_pkg::RANK_W-1:0]   out_picked_rank,
  output logic [rwrs_pkg::STATUS_W-1:0] out_status,
  // Configuration port.
  input  logic                          cfg_wr_en,
  input  logic [rwrs_pkg::POOL_W-1:0]   cfg_wr_data
);
  import rwrs_pkg::*;

  localparam int IDX_W   = $clog2(MAX_POOL);
  localparam int SIZE_W  = $clog2(MAX_POOL + 1);
  localparam int MAX_TOT = MAX_POOL * (MAX_POOL + 1) / 2;
  localparam int CUM_W   = $clog2(MAX_TOT + 1);
  localparam int LHS_W   = RAND_BITS + CUM_W;
  localparam int CMP_W   = (POOL_W > SIZE_W) ? POOL_W : SIZE_W;
  localparam int REXT_W  = (RAND_W > RAND_BITS) ? RAND_W : RAND_BITS;
  localparam int PICK_W  = (IDX_W > RANK_W) ? IDX_W : RANK_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [POOL_W-1:0]     pool_size_r;
  logic [SIZE_W-1:0]     table_size_r, table_size_nxt;
  logic [SIZE_W-1:0]     last_pick_r, last_pick_nxt;
  logic [SIZE_W-1:0]     build_n_r, build_n_nxt;
  logic [SIZE_W-1:0]     idx_r, idx_nxt;
  logic [CUM_W-1:0]      acc_r, acc_nxt;
  logic [CUM_W-1:0]      total_r, total_nxt;
  logic [RAND_BITS-1:0]  rand_r;
  logic [LHS_W-1:0]      lhs_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]     out_rank_r, out_rank_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // Cumulative weight memory.
  logic [CUM_W-1:0]      mem [MAX_POOL];
  logic [CUM_W-1:0]      mem_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [CUM_W-1:0]      acc_sum;

  logic                  in_fire;
  logic                  out_free;
  logic [CMP_W-1:0]      pool_ext;
  logic [SIZE_W-1:0]     n_sat;
  logic [REXT_W-1:0]     rand_ext;
  logic                  hit;
  logic                  scan_last;
  logic                  build_last;
  logic [SIZE_W-1:0]     pick_size;
  logic [PICK_W-1:0]     pick_wide;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_picked_rank = out_rank_r;
  assign out_status      = out_status_r;

  // Pool size saturated to the table depth.
  assign pool_ext = CMP_W'(pool_size_r);
  assign n_sat    = (pool_ext > CMP_W'(MAX_POOL)) ? SIZE_W'(MAX_POOL) : SIZE_W'(pool_ext);

  // Only the low RAND_BITS bits of the fraction take part.
  assign rand_ext = REXT_W'(in_rand_fraction);

  // Build step: the weight of rank k is n - k.
  assign acc_sum    = acc_r + CUM_W'(build_n_r - idx_r);
  assign build_last = (idx_r == build_n_r - SIZE_W'(1));
  assign wr_addr    = idx_r[IDX_W-1:0];
  assign mem_we     = (state_r == ST_BUILD);

  // Scan step: first rank whose cumulative weight exceeds fraction times total.
  assign hit       = lhs_r < {mem_q, {RAND_BITS{1'b0}}};
  assign scan_last = (idx_r == table_size_r - SIZE_W'(1));
  assign pick_size = idx_r;
  assign pick_wide = PICK_W'(idx_r[IDX_W-1:0]);

  // The read address follows the next scan index, so a held scan rereads
  // the same entry.
  assign rd_addr = idx_nxt[IDX_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    table_size_nxt = table_size_r;
    last_pick_nxt  = last_pick_r;
    build_n_nxt    = build_n_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rank_nxt   = out_rank_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_BEGIN) begin
            last_pick_nxt = SIZE_W'(MAX_POOL);
            if (n_sat != table_size_r) begin
              if (n_sat == '0) begin
                table_size_nxt = '0;
                total_nxt      = '0;
              end else begin
                build_n_nxt = n_sat;
                idx_nxt     = '0;
                acc_nxt     = '0;
                state_nxt   = ST_BUILD;
              end
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_BUILD: begin
        acc_nxt = acc_sum;
        if (build_last) begin
          table_size_nxt = build_n_r;
          total_nxt      = acc_sum;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt = idx_r + SIZE_W'(1);
        end
      end
      ST_MUL: begin
        // The product lands in lhs_r; entry 0 is read meanwhile.
        idx_nxt = '0;
        if (table_size_r == '0) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_rank_nxt   = '0;
            out_status_nxt = STATUS_EMPTY;
            state_nxt      = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_last) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_rank_nxt  = pick_wide[RANK_W-1:0];
            if (pick_size == last_pick_r) begin
              out_status_nxt = STATUS_REPEAT;
            end else begin
              out_status_nxt = STATUS_OK;
              last_pick_nxt  = pick_size;
            end
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SIZE_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pool_size_r  <= '0;
      table_size_r <= '0;
      last_pick_r  <= SIZE_W'(MAX_POOL);
      build_n_r    <= '0;
      idx_r        <= '0;
      acc_r        <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        pool_size_r <= cfg_wr_data;
      end
      table_size_r <= table_size_nxt;
      last_pick_r  <= last_pick_nxt;
      build_n_r    <= build_n_nxt;
      idx_r        <= idx_nxt;
      acc_r        <= acc_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_rank_r   <= out_rank_nxt;
    out_status_r <= out_status_nxt;
    if (in_fire) begin
      rand_r <= rand_ext[RAND_BITS-1:0];
    end
    if (state_r == ST_MUL) begin
      lhs_r <= LHS_W'(rand_r) * LHS_W'(total_r);
    end
  end

  // Table memory: one write port for rebuilds, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= acc_sum;
    end
    mem_q <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rwrs_checker.sv =====
// ----------------------------------------------------------------------------
// rwrs_checker
// Port-level checks of the rank-weighted roulette selector, bound to the
// top level.
// ----------------------------------------------------------------------------
module rwrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rwrs_pkg::OPCODE_W-1:0] in_opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rwrs_pkg::RANK_W-1:0]   out_picked_rank,
  input logic [rwrs_pkg::STATUS_W-1:0] out_status
);
  import rwrs_pkg::*;

  // No result item is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result item carries a defined status.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_REPEAT ||
                   out_status == STATUS_EMPTY))
    else $error("undefined status code");

  // An empty pool always reports rank zero.
  a_empty_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_EMPTY) |-> (out_picked_rank == '0))
    else $error("empty pool with nonzero rank");

  // A draw keeps the block busy for at least the following cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_DRAW) |=> !in_ready)
    else $error("item accepted during draw multiply");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_picked_rank) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind rank_weighted_roulette_select rwrs_checker u_rwrs_checker (.*);

// ===== tb/rwrs_pick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_pick_checker
// Watches the input, result and configuration ports of the rank-weighted
// roulette selector, predicts each draw result from its own copy of the
// pool size, table size and last accepted rank, and compares every result
// item field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rwrs_pick_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [rwrs_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [rwrs_pkg::RAND_W-1:0]   in_rand_fraction,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rwrs_pkg::RANK_W-1:0]   out_picked_rank,
  input  logic [rwrs_pkg::STATUS_W-1:0] out_status,
  input  logic                          cfg_wr_en,
  input  logic [rwrs_pkg::POOL_W-1:0]   cfg_wr_data,
  output int                            mismatch_count,
  output int                            picks_pending,
  output int                            picks_checked
);
  import rwrs_pkg::*;

  // Rank value that marks "no accepted pick yet in this round".
  localparam logic [POOL_W-1:0] NO_PICK = POOL_W'(DEF_MAX_POOL);

  typedef struct packed {
    logic [RANK_W-1:0]   rank;
    logic [STATUS_W-1:0] status;
  } pick_t;

  pick_t             expected_picks[$];
  logic [POOL_W-1:0] pool_reg;
  logic [POOL_W-1:0] table_n;
  logic [POOL_W-1:0] last_rank;

  // First rank whose cumulative linear weight exceeds fraction times total.
  // The cumulative weight is summed on the fly, so no table is kept here.
  function automatic logic [POOL_W-1:0] roulette_rank(input logic [POOL_W-1:0] n,
                                                      input logic [RAND_W-1:0] frac);
    longint unsigned total;
    longint unsigned scaled;
    longint unsigned cum;
    int              y;
    total  = longint'(n) * (longint'(n) + 1) / 2;
    scaled = longint'(frac) * total;
    cum    = 0;
    for (y = 0; y < n; y++) begin
      cum += longint'(n) - y;
      if (scaled < (cum << DEF_RAND_BITS)) return POOL_W'(y);
    end
    return n - 1'b1;
  endfunction

  always @(posedge clk) begin
    pick_t             want;
    pick_t             guess;
    logic [POOL_W-1:0] rank;
    logic              bad;
    if (!rst_n) begin
      pool_reg = '0;
      table_n  = '0;
      last_rank = NO_PICK;
      expected_picks.delete();
      mismatch_count <= 0;
      picks_pending  <= 0;
      picks_checked  <= 0;
    end else begin
      // Compare a result item with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result item, rank %0d status %0d",
                   $time, out_picked_rank, out_status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_picks.pop_front();
          bad  = 1'b0;
          if (out_picked_rank !== want.rank) begin
            $display("%0t: picked_rank mismatch, expected %0d, actual %0d",
                     $time, want.rank, out_picked_rank);
            bad = 1'b1;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            bad = 1'b1;
          end
          if (bad) mismatch_count <= mismatch_count + 1;
          picks_checked <= picks_checked + 1;
        end
      end

      // Predict the effect of an accepted input item; it sees the pool size
      // from before any write at the same edge.
      if (in_valid && in_ready) begin
        if (in_opcode == OP_BEGIN) begin
          last_rank = NO_PICK;
          table_n   = (pool_reg > DEF_MAX_POOL) ? POOL_W'(DEF_MAX_POOL) : pool_reg;
        end else begin
          if (table_n == 0) begin
            guess.rank   = '0;
            guess.status = STATUS_EMPTY;
          end else begin
            rank       = roulette_rank(table_n, in_rand_fraction);
            guess.rank = rank[RANK_W-1:0];
            if (rank == last_rank) begin
              guess.status = STATUS_REPEAT;
            end else begin
              last_rank    = rank;
              guess.status = STATUS_OK;
            end
          end
          expected_picks.insert(expected_picks.size(), guess);
        end
      end

      // Track the pool size register.
      if (cfg_wr_en) pool_reg = cfg_wr_data;

      picks_pending <= expected_picks.size();
    end
  end

endmodule

// ===== tb/tb_rank_weighted_roulette_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rank_weighted_roulette_select
// Drives begin-round and draw items into the roulette selector under random
// sender and receiver stalls, rewrites the pool size between rounds and in
// mid-round, and leaves result checking to rwrs_pick_checker and rwrs_checker.
// ----------------------------------------------------------------------------
module tb_rank_weighted_roulette_select;
  import rwrs_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS   = 567;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode        = OP_BEGIN;
  logic [RAND_W-1:0]   in_rand_fraction = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [RANK_W-1:0]   out_picked_rank;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_wr_en        = 1'b0;
  logic [POOL_W-1:0]   cfg_wr_data      = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int begin_items   = 0;
  int draw_items    = 0;
  int pool_writes   = 0;
  int cycle_count   = 0;
  int mismatch_count;
  int picks_pending;
  int picks_checked;

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rank_weighted_roulette_select uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_rand_fraction (in_rand_fraction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_picked_rank  (out_picked_rank),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  rwrs_pick_checker pick_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_rand_fraction (in_rand_fraction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_picked_rank  (out_picked_rank),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .picks_pending    (picks_pending),
    .picks_checked    (picks_checked)
  );

  // Receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_rank_weighted_roulette_select: done, errors");
    $finish;
  end

  // Offers one item, with an optional random gap first, and returns at the
  // edge where it is accepted. Valid stays high so the next item can follow.
  task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [RAND_W-1:0] frac);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_rand_fraction <= frac;
    do @(posedge clk); while (!in_ready);
    if (op == OP_BEGIN) begin_items++;
    else draw_items++;
  endtask

  // Drains every outstanding result, then waits out a possible table rebuild.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (picks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the pool size while the block is idle.
  task automatic write_pool(input logic [POOL_W-1:0] pool_n);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pool_n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_writes++;
  endtask

  // Fractions lean toward both ends of the range.
  function automatic logic [RAND_W-1:0] random_fraction();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return '1;
    return RAND_W'($urandom_range(16'hFFFF));
  endfunction

  // Pool sizes are mostly small; full, oversized and empty pools are rarer.
  function automatic logic [POOL_W-1:0] random_pool_size();
    int p;
    p = $urandom_range(99);
    if (p < 5) return '0;
    if (p < 12) return POOL_W'(1);
    if (p < 20) return POOL_W'(DEF_MAX_POOL);
    if (p < 25) return POOL_W'($urandom_range(DEF_MAX_POOL + 1, 511));
    if (p < 32) return POOL_W'($urandom_range(128, DEF_MAX_POOL - 1));
    return POOL_W'($urandom_range(2, 24));
  endfunction

  // Mostly whole rounds with random content, plus mid-round size changes
  // and stray items.
  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int goal;
    int kind;
    int draws;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = begin_items + draw_items + n_items;
    while (begin_items + draw_items < goal) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        push_item(OPCODE_W'($urandom_range(1)), random_fraction());
      end else if (kind < 15) begin
        write_pool(random_pool_size());
        draws = $urandom_range(1, 4);
        repeat (draws) push_item(OP_DRAW, random_fraction());
      end else begin
        if ($urandom_range(99) < 55) write_pool(random_pool_size());
        push_item(OP_BEGIN, random_fraction());
        draws = $urandom_range(1, 10);
        repeat (draws) push_item(OP_DRAW, random_fraction());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 85;

    // A draw before any round, and a round over an empty pool.
    push_item(OP_DRAW, 16'h1234);
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, 16'hFFFF);

    // Single individual: the second draw in a round is a repeat.
    write_pool(POOL_W'(1));
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, 16'hFFFF);
    push_item(OP_BEGIN, 16'hFFFF);
    push_item(OP_DRAW, 16'h8000);

    // Full pool, both ends of the fraction and repeats of each.
    write_pool(POOL_W'(DEF_MAX_POOL));
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, 16'hFFFF);
    push_item(OP_DRAW, 16'hFFFF);
    push_item(OP_DRAW, 16'h8000);

    // Size change in mid-round keeps the old table until the next round.
    write_pool(POOL_W'(5));
    push_item(OP_DRAW, 16'hFFFF);
    push_item(OP_DRAW, '0);
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, 16'hFFFF);

    // Oversized pools saturate to the full table.
    write_pool('1);
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, 16'hFFFF);
    write_pool(POOL_W'(300));
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, '0);

    // Smallest pool that can choose.
    write_pool(POOL_W'(2));
    push_item(OP_BEGIN, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, 16'hFFFF);
    push_item(OP_DRAW, 16'hAAAA);

    // Random part under three idling patterns.
    run_phase(23, 85, PHASE_ITEMS);
    run_phase(85, 23, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    settle_block();
    $display("Run covered %0d begin-round items, %0d draw items and %0d pool size writes;",
             begin_items, draw_items, pool_writes);
    $display("%0d result items were checked.", picks_checked);
    if (mismatch_count == 0 && picks_pending == 0) begin
      $display("tb_rank_weighted_roulette_select: done, clean");
    end else begin
      $display("tb_rank_weighted_roulette_select: done, errors");
    end
    $finish;
  end

endmodule
